// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry concurrent checks.
// Depends on nothing; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rgbg_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, register codes and payload types of the RGB565 and gray downscale block.
// Depends on nothing; used by the interfaces, the scale divider and the top level.
package rgbg_pkg;

   // Frame and gray image geometry.
   localparam int FRAME_WIDTH  = 320;
   localparam int FRAME_HEIGHT = 240;
   localparam int GRAY_COLUMNS = 96;
   localparam int GRAY_ROWS    = 96;

   // Field widths.
   localparam int COORD_W     = 11;
   localparam int COLOR_W     = 8;
   localparam int SRC_W       = 11;
   localparam int STRIDE_W    = 9;
   localparam int RGB565_W    = 16;
   localparam int FRAME_IDX_W = 17;
   localparam int GRAY_IDX_W  = 14;
   localparam int SAMPLE_W    = 8;
   localparam int LUMA_W      = 16;

   // Configuration port.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_DECODED_WIDTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_ENABLE   = CSR_IDX_W'(3);

   // Register reset values.
   localparam logic [STRIDE_W-1:0] DECODED_WIDTH_RST = STRIDE_W'(320);
   localparam logic [SRC_W-1:0]    SOURCE_WIDTH_RST  = SRC_W'(320);
   localparam logic [SRC_W-1:0]    SOURCE_HEIGHT_RST = SRC_W'(240);

   // The stride never exceeds the frame width; the cap is limited to what the register holds.
   localparam int STRIDE_CAP = (FRAME_WIDTH > (1 << STRIDE_W) - 1) ?
                               (1 << STRIDE_W) - 1 : FRAME_WIDTH;

   // Luma weights, BT.601 in units of 1/256.
   localparam int LUMA_R_COEF = 77;
   localparam int LUMA_G_COEF = 150;
   localparam int LUMA_B_COEF = 29;

   // Scaled coordinates: the quotient carries one bit at or above the larger gray size,
   // which flags saturation.
   localparam int GRAY_MAX        = (GRAY_COLUMNS > GRAY_ROWS) ? GRAY_COLUMNS : GRAY_ROWS;
   localparam int QUOT_W          = $clog2(GRAY_MAX) + 1;
   localparam int DIV_W           = SRC_W + QUOT_W;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = (QUOT_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   // Input register, arithmetic stage, divider stages and the output register.
   localparam int PIPE_DEPTH = DIV_STAGES + 3;

   localparam int FIDX_WIDE_W    = COORD_W + STRIDE_W;
   localparam int GIDX_WIDE_W    = 2 * QUOT_W + 2;
   localparam int GRAY_IDX_COUNT = GRAY_COLUMNS * GRAY_ROWS;

   // Result fields that travel alongside the divider stages.
   typedef struct packed {
      logic [RGB565_W-1:0]        rgb565_word;
      logic [FRAME_IDX_W-1:0]     frame_index;
      logic                       gray_valid;
      logic signed [SAMPLE_W-1:0] gray_sample;
   } carry_type;

   // One complete result transaction.
   typedef struct packed {
      logic [RGB565_W-1:0]        rgb565_word;
      logic [FRAME_IDX_W-1:0]     frame_index;
      logic                       gray_valid;
      logic [GRAY_IDX_W-1:0]      gray_index;
      logic signed [SAMPLE_W-1:0] gray_sample;
   } result_type;

endpackage

// ----- rtl/rgbg_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the block: pixel requests, results and register writes.
// Depends on rgbg_pkg for the field widths.

// Decoded pixel channel.
interface rgbg_req_if import rgbg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] column;
   logic [COORD_W-1:0] row;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;

   modport source (output valid, column, row, red, green, blue, input ready);
   modport sink   (input valid, column, row, red, green, blue, output ready);
endinterface

// Result channel.
interface rgbg_rsp_if import rgbg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [RGB565_W-1:0]        rgb565_word;
   logic [FRAME_IDX_W-1:0]     frame_index;
   logic                       gray_valid;
   logic [GRAY_IDX_W-1:0]      gray_index;
   logic signed [SAMPLE_W-1:0] gray_sample;

   modport source (output valid, rgb565_word, frame_index, gray_valid, gray_index,
                   gray_sample, input ready);
   modport sink   (input valid, rgb565_word, frame_index, gray_valid, gray_index,
                   gray_sample, output ready);
endinterface

// Register write channel.
interface rgbg_csr_if import rgbg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/rgbg_scale_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider that scales one coordinate into the gray image.
// Depends on rgbg_pkg; two quotient bits are resolved per register stage.
module rgbg_scale_div import rgbg_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] stage_en,
   input  logic [DIV_W-1:0]      numer,
   input  logic [SRC_W-1:0]      denom,
   output logic [QUOT_W-1:0]     quot
);

   logic [DIV_W-1:0]  rem_ff   [DIV_STAGES];
   logic [QUOT_W-1:0] quot_ff  [DIV_STAGES];
   logic [DIV_W-1:0]  rem_in   [DIV_STAGES];
   logic [QUOT_W-1:0] quot_in  [DIV_STAGES];
   logic [DIV_W-1:0]  rem_src  [DIV_STAGES];
   logic [QUOT_W-1:0] quot_src [DIV_STAGES];

   // Each stage starts from the partial remainder of the stage before it.
   assign rem_src[0]  = numer;
   assign quot_src[0] = '0;
   for (genvar s = 1; s < DIV_STAGES; s++) begin : g_link
      assign rem_src[s]  = rem_ff[s-1];
      assign quot_src[s] = quot_ff[s-1];
   end

   // Compare and subtract the shifted divisor, most significant quotient bit first.
   // The top bit stays set when the true quotient overflows, which forces saturation later.
   always_comb begin
      logic [DIV_W-1:0]  r;
      logic [QUOT_W-1:0] q;
      logic [DIV_W-1:0]  d;
      int                k;
      for (int s = 0; s < DIV_STAGES; s++) begin
         r = rem_src[s];
         q = quot_src[s];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            k = QUOT_W - 1 - (s * STEPS_PER_STAGE + j);
            if (k >= 0) begin
               d = DIV_W'(denom) << k;
               if (r >= d) begin
                  r    = r - d;
                  q[k] = 1'b1;
               end
            end
         end
         rem_in[s]  = r;
         quot_in[s] = q;
      end
   end

   // Stage registers advance with the pipeline enables of the top level.
   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (stage_en[s]) begin
            rem_ff[s]  <= rem_in[s];
            quot_ff[s] <= quot_in[s];
         end
      end
   end

   assign quot = quot_ff[DIV_STAGES-1];

endmodule

// ----- rtl/rgb_to_rgb565_and_gray_downscale_top.sv -----
`timescale 1ns / 1ps
// Top level: RGB888 pixel to RGB565 frame-buffer word and downscaled luma sample.
// Depends on rgbg_pkg, rgbg_if, rgbg_scale_div and assert_macros.svh.
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    column, row, red, green, blue
//   rsp_bus   out  valid/ready    rgb565_word, frame_index, gray_valid, gray_index, gray_sample
//   csr_bus   in   valid/ready    index, data (always ready)
//
// One transaction per cycle is taken unless back-pressure on rsp_bus fills the pipeline.
// PIPE_DEPTH is set by the restoring division of the gray coordinates, two bits per stage.
// Pixels outside the frame are dropped at the input register and give no result.
// Each stage holds while the stage after it is full and blocked; empty stages still fill.
// Synchronous reset clears all valid bits and loads the register defaults.
`include "assert_macros.svh"

module rgb_to_rgb565_and_gray_downscale_top import rgbg_pkg::*; (
   input logic        clock,
   input logic        reset,
   rgbg_req_if.sink   req_bus,
   rgbg_rsp_if.source rsp_bus,
   rgbg_csr_if.sink   csr_bus
);

   // Configuration registers.
   logic [STRIDE_W-1:0] decoded_width_ff;
   logic [SRC_W-1:0]    source_width_ff;
   logic [SRC_W-1:0]    source_height_ff;
   logic                gray_enable_ff;

   // Pipeline control.
   logic [PIPE_DEPTH-1:0] v_ff;
   logic [PIPE_DEPTH-1:0] en;
   logic [DIV_STAGES-1:0] div_en;
   logic                  req_accept;
   logic                  in_frame;

   // Input register.
   logic [COORD_W-1:0] col0_ff;
   logic [COORD_W-1:0] row0_ff;
   logic [COLOR_W-1:0] red0_ff;
   logic [COLOR_W-1:0] green0_ff;
   logic [COLOR_W-1:0] blue0_ff;

   // Arithmetic stage.
   logic [STRIDE_W-1:0]    stride;
   logic [FIDX_WIDE_W-1:0] fidx_wide;
   logic [LUMA_W-1:0]      luma_sum;
   carry_type              carry_in;
   logic [DIV_W-1:0]       num_x_in;
   logic [DIV_W-1:0]       num_y_in;
   logic [DIV_W-1:0]       num_x_ff;
   logic [DIV_W-1:0]       num_y_ff;
   carry_type              carry_ff [DIV_STAGES+1];

   // Divider results and output stage.
   logic [QUOT_W-1:0]      quot_x;
   logic [QUOT_W-1:0]      quot_y;
   logic [QUOT_W-1:0]      dx;
   logic [QUOT_W-1:0]      dy;
   logic [GIDX_WIDE_W-1:0] gidx_wide;
   carry_type              carry_last;
   result_type             result_in;
   result_type             result_ff;

   // Register writes; indexes beyond the list are ignored.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decoded_width_ff <= DECODED_WIDTH_RST;
         source_width_ff  <= SOURCE_WIDTH_RST;
         source_height_ff <= SOURCE_HEIGHT_RST;
         gray_enable_ff   <= 1'b0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_DECODED_WIDTH: decoded_width_ff <= csr_bus.data[STRIDE_W-1:0];
            CSR_SOURCE_WIDTH:  source_width_ff  <= csr_bus.data[SRC_W-1:0];
            CSR_SOURCE_HEIGHT: source_height_ff <= csr_bus.data[SRC_W-1:0];
            CSR_GRAY_ENABLE:   gray_enable_ff   <= csr_bus.data[0];
            default: ;
         endcase
      end
   end

   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      en[PIPE_DEPTH-1] = !v_ff[PIPE_DEPTH-1] || rsp_bus.ready;
      for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign div_en        = en[DIV_STAGES+1:2];
   assign req_bus.ready = en[0];
   assign req_accept    = req_bus.valid && en[0];
   assign in_frame      = (req_bus.column < COORD_W'(FRAME_WIDTH)) &&
                          (req_bus.row < COORD_W'(FRAME_HEIGHT));

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_accept && in_frame;
         end
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         col0_ff   <= req_bus.column;
         row0_ff   <= req_bus.row;
         red0_ff   <= req_bus.red;
         green0_ff <= req_bus.green;
         blue0_ff  <= req_bus.blue;
      end
   end

   // Packing, frame-buffer index, luma and the scaled-coordinate numerators.
   always_comb begin
      stride = (decoded_width_ff < STRIDE_W'(STRIDE_CAP)) ? decoded_width_ff
                                                          : STRIDE_W'(STRIDE_CAP);
      fidx_wide = FIDX_WIDE_W'(row0_ff) * FIDX_WIDE_W'(stride) + FIDX_WIDE_W'(col0_ff);
      luma_sum  = LUMA_W'(red0_ff) * LUMA_W'(LUMA_R_COEF) +
                  LUMA_W'(green0_ff) * LUMA_W'(LUMA_G_COEF) +
                  LUMA_W'(blue0_ff) * LUMA_W'(LUMA_B_COEF);

      carry_in.rgb565_word = {red0_ff[7:3], green0_ff[7:2], blue0_ff[7:3]};
      carry_in.frame_index = fidx_wide[FRAME_IDX_W-1:0];
      carry_in.gray_valid  = gray_enable_ff && (source_width_ff != '0) &&
                             (source_height_ff != '0);
      // Subtracting 128 from an 8-bit luma flips its top bit.
      carry_in.gray_sample = $signed({~luma_sum[LUMA_W-1], luma_sum[LUMA_W-2:LUMA_W-SAMPLE_W]});

      num_x_in = DIV_W'(col0_ff) * DIV_W'(GRAY_COLUMNS);
      num_y_in = DIV_W'(row0_ff) * DIV_W'(GRAY_ROWS);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         carry_ff[0] <= carry_in;
         num_x_ff    <= num_x_in;
         num_y_ff    <= num_y_in;
      end
   end

   // Side fields follow the divider stages.
   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (en[s+2]) begin
            carry_ff[s+1] <= carry_ff[s];
         end
      end
   end

   rgbg_scale_div u_div_x (
      .clock    (clock),
      .stage_en (div_en),
      .numer    (num_x_ff),
      .denom    (source_width_ff),
      .quot     (quot_x)
   );

   rgbg_scale_div u_div_y (
      .clock    (clock),
      .stage_en (div_en),
      .numer    (num_y_ff),
      .denom    (source_height_ff),
      .quot     (quot_y)
   );

   // Saturate the scaled coordinates and form the gray index; gray fields read zero when off.
   always_comb begin
      carry_last = carry_ff[DIV_STAGES];
      dx = (quot_x >= QUOT_W'(GRAY_COLUMNS)) ? QUOT_W'(GRAY_COLUMNS - 1) : quot_x;
      dy = (quot_y >= QUOT_W'(GRAY_ROWS)) ? QUOT_W'(GRAY_ROWS - 1) : quot_y;
      gidx_wide = GIDX_WIDE_W'(dy) * GIDX_WIDE_W'(GRAY_COLUMNS) + GIDX_WIDE_W'(dx);

      result_in.rgb565_word = carry_last.rgb565_word;
      result_in.frame_index = carry_last.frame_index;
      result_in.gray_valid  = carry_last.gray_valid;
      if (carry_last.gray_valid) begin
         result_in.gray_index  = gidx_wide[GRAY_IDX_W-1:0];
         result_in.gray_sample = carry_last.gray_sample;
      end else begin
         result_in.gray_index  = '0;
         result_in.gray_sample = '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (en[PIPE_DEPTH-1]) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid       = v_ff[PIPE_DEPTH-1];
   assign rsp_bus.rgb565_word = result_ff.rgb565_word;
   assign rsp_bus.frame_index = result_ff.frame_index;
   assign rsp_bus.gray_valid  = result_ff.gray_valid;
   assign rsp_bus.gray_index  = result_ff.gray_index;
   assign rsp_bus.gray_sample = result_ff.gray_sample;

   // Checks on the pipeline and the result fields.
   `ASSERT_NEXT(a_drop_out_of_frame, clock, reset, req_accept && !in_frame, !v_ff[0], "out-of-frame pixel entered the pipeline")
   `ASSERT_NEXT(a_blocked_stage_holds, clock, reset, v_ff[1] && !en[1], v_ff[1], "blocked arithmetic stage lost its transaction")
   `ASSERT_SAME(a_gray_off_zero, clock, reset, rsp_bus.valid && !rsp_bus.gray_valid, (rsp_bus.gray_index == '0) && (rsp_bus.gray_sample == '0), "gray fields not zero while gray is off")
   `ASSERT_SAME(a_gray_index_range, clock, reset, rsp_bus.valid && rsp_bus.gray_valid, rsp_bus.gray_index < GRAY_IDX_COUNT, "gray index beyond the gray image")

endmodule
